FILE: hw/rtl/dtfr_pkg.sv
// Shared types, sizes and display command codes of the dirty tracking frame refresh core.
package dtfr_pkg;

	localparam int COLUMNS = 128;
	localparam int PAGES   = 8;

	// Dirty marks are kept in words of DIRTY_W columns so that a scan tests many at once.
	localparam int DIRTY_W = 16;
	localparam int BIT_W   = $clog2(DIRTY_W);
	localparam int WPP     = (COLUMNS + DIRTY_W - 1) / DIRTY_W;
	localparam int COL_W   = $clog2(COLUMNS);
	localparam int PAGE_W  = (PAGES > 1) ? $clog2(PAGES) : 1;
	localparam int WRD_W   = (WPP > 1) ? $clog2(WPP) : 1;
	localparam int FA_W    = PAGE_W + COL_W;
	localparam int DA_W    = PAGE_W + WRD_W;
	localparam int FDEPTH  = 1 << FA_W;
	localparam int DDEPTH  = 1 << DA_W;
	localparam int SCAN_N  = PAGES * WPP + 1;
	localparam int SCNT_W  = $clog2(SCAN_N);

	localparam logic [7:0] PAGE_CMD   = 8'hb0;
	localparam logic [7:0] COL_HI_CMD = 8'h10;
	localparam logic [7:0] LO_MASK    = 8'h0f;
	localparam logic [7:0] HI_MASK    = 8'hf0;

	typedef enum logic [1:0] {
		ACT_DRAW    = 2'd0,
		ACT_WRITE   = 2'd1,
		ACT_CLEAR   = 2'd2,
		ACT_REFRESH = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		OUT_PAGE,
		OUT_HI,
		OUT_LO,
		OUT_DATA,
		OUT_DONE
	} out_kind_t;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] x;
		logic [7:0] y;
		logic       pixel_on;
		logic [2:0] page;
		logic [7:0] byte_value;
	} item_t;

	typedef struct packed {
		logic      take_item;
		logic      sweep_step;
		logic      sweep_dirty;
		logic      frm_rd;
		logic      frm_wr;
		logic      scan_start;
		logic      scan_rd;
		logic      scan_eval;
		logic      scan_next;
		logic      hit_rd;
		logic      out_load;
		out_kind_t out_sel;
		logic      done_upd;
	} dtfr_cmd_t;

	typedef struct packed {
		action_t act;
		logic    in_range;
		logic    differs;
		logic    hit;
		logic    scan_end;
		logic    sweep_end;
		logic    page_needed;
		logic    out_free;
	} dtfr_stat_t;

endpackage

FILE: hw/rtl/dtfr_in_if.sv
// Input channel interface: one action item with valid and ready.
interface dtfr_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [7:0] x;
	logic [7:0] y;
	logic       pixel_on;
	logic [2:0] page;
	logic [7:0] byte_value;

	modport source (output valid, action, x, y, pixel_on, page, byte_value, input ready);
	modport sink (input valid, action, x, y, pixel_on, page, byte_value, output ready);
endinterface

FILE: hw/rtl/dtfr_out_if.sv
// Output channel interface: one display byte item with valid and ready.
interface dtfr_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       is_data;
	logic       last;
	logic       done_res;

	modport source (output valid, out_byte, is_data, last, done_res, input ready);
	modport sink (input valid, out_byte, is_data, last, done_res, output ready);
endinterface

FILE: hw/rtl/dtfr_ctrl.sv
// Controller state machine that sequences draw, write, clear and refresh work.
module dtfr_ctrl import dtfr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  dtfr_stat_t stat,
	output dtfr_cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_DECODE,
		S_FRM_RD,
		S_MODIFY,
		S_SWEEP,
		S_SCAN_START,
		S_SCAN_RD,
		S_SCAN_EV,
		S_HIT_RD,
		S_EMIT_PG,
		S_EMIT_HI,
		S_EMIT_LO,
		S_EMIT_DATA,
		S_DONE
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd     = '0;
		cmd.out_sel = OUT_PAGE;
		state_d = state_q;
		unique case (state_q)
			S_INIT: begin
				cmd.sweep_step  = 1'b1;
				cmd.sweep_dirty = 1'b0;
				if (stat.sweep_end) state_d = S_IDLE;
			end
			S_IDLE: begin
				cmd.take_item = in_valid;
				if (in_valid) state_d = S_DECODE;
			end
			S_DECODE: begin
				unique case (stat.act) inside
					ACT_DRAW, ACT_WRITE: state_d = stat.in_range ? S_FRM_RD : S_IDLE;
					ACT_CLEAR:           state_d = S_SWEEP;
					ACT_REFRESH:         state_d = S_SCAN_START;
					default:             state_d = S_IDLE;
				endcase
			end
			S_FRM_RD: begin
				cmd.frm_rd = 1'b1;
				state_d    = S_MODIFY;
			end
			S_MODIFY: begin
				// A draw always marks its byte; a write only when the byte changes.
				cmd.frm_wr = (stat.act == ACT_DRAW) || stat.differs;
				state_d    = S_IDLE;
			end
			S_SWEEP: begin
				cmd.sweep_step  = 1'b1;
				cmd.sweep_dirty = 1'b1;
				if (stat.sweep_end) state_d = S_IDLE;
			end
			S_SCAN_START: begin
				cmd.scan_start = 1'b1;
				state_d        = S_SCAN_RD;
			end
			S_SCAN_RD: begin
				cmd.scan_rd = 1'b1;
				state_d     = S_SCAN_EV;
			end
			S_SCAN_EV: begin
				cmd.scan_eval = 1'b1;
				if (stat.hit) begin
					state_d = S_HIT_RD;
				end else if (stat.scan_end) begin
					state_d = S_DONE;
				end else begin
					cmd.scan_next = 1'b1;
					state_d       = S_SCAN_RD;
				end
			end
			S_HIT_RD: begin
				cmd.hit_rd = 1'b1;
				state_d    = stat.page_needed ? S_EMIT_PG : S_EMIT_HI;
			end
			S_EMIT_PG: begin
				cmd.out_sel  = OUT_PAGE;
				cmd.out_load = stat.out_free;
				if (stat.out_free) state_d = S_EMIT_HI;
			end
			S_EMIT_HI: begin
				cmd.out_sel  = OUT_HI;
				cmd.out_load = stat.out_free;
				if (stat.out_free) state_d = S_EMIT_LO;
			end
			S_EMIT_LO: begin
				cmd.out_sel  = OUT_LO;
				cmd.out_load = stat.out_free;
				if (stat.out_free) state_d = S_EMIT_DATA;
			end
			S_EMIT_DATA: begin
				cmd.out_sel  = OUT_DATA;
				cmd.out_load = stat.out_free;
				if (stat.out_free) state_d = S_IDLE;
			end
			S_DONE: begin
				cmd.out_sel  = OUT_DONE;
				cmd.out_load = stat.out_free;
				cmd.done_upd = stat.out_free;
				if (stat.out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: hw/rtl/dtfr_dpath.sv
// Datapath with the frame store, the dirty mark memory, the scan cursor and the output register.
module dtfr_dpath import dtfr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  dtfr_cmd_t  cmd,
	output dtfr_stat_t stat,
	input  item_t      item,
	input  logic       out_ready,
	output logic       out_valid,
	output logic [7:0] out_byte,
	output logic       is_data,
	output logic       last,
	output logic       done_res
);

	// Memories.
	logic [7:0]         fmem [FDEPTH];
	logic [DIRTY_W-1:0] dmem [DDEPTH];

	item_t              it_q;
	logic [7:0]         frd_q;
	logic [DIRTY_W-1:0] drd_q;

	logic [FA_W-1:0]    sweep_q;
	logic [PAGE_W-1:0]  cur_page_q;
	logic [COL_W-1:0]   cur_col_q;
	logic               page_valid_q;
	logic [PAGE_W-1:0]  sent_page_q;

	logic [PAGE_W-1:0]  sp_q;
	logic [WRD_W-1:0]   sw_q;
	logic [SCNT_W-1:0]  scnt_q;
	logic [BIT_W-1:0]   start_bit_q;
	logic               first_q;

	logic [PAGE_W-1:0]  hit_page_q;
	logic [WRD_W-1:0]   hit_word_q;
	logic [BIT_W-1:0]   hit_bit_q;
	logic [COL_W-1:0]   hit_col_q;

	logic               out_valid_q;
	logic [7:0]         out_byte_q;
	logic               is_data_q;
	logic               last_q;
	logic               done_q;

	action_t            act;
	logic [8:0]         x9;
	logic [4:0]         ipg5;
	logic [FA_W-1:0]    item_faddr;
	logic [WRD_W-1:0]   item_word;
	logic [7:0]         pix_mask;
	logic [7:0]         new_byte;

	logic               fwe;
	logic [FA_W-1:0]    fwaddr;
	logic [7:0]         fwdata;
	logic               fre;
	logic [FA_W-1:0]    fraddr;

	logic               dwe;
	logic [DA_W-1:0]    dwaddr;
	logic [DIRTY_W-1:0] dwmask;
	logic [DIRTY_W-1:0] dwdata;

	logic [8:0]         curcol9;
	logic [8:0]         col_base9;
	logic [DIRTY_W-1:0] vmask;
	logic [DIRTY_W-1:0] fmask;
	logic [DIRTY_W-1:0] masked;
	logic [BIT_W-1:0]   hit_bit;
	logic [8:0]         hit_col9;
	logic [7:0]         col8;

	// Item decode.
	assign act        = action_t'(it_q.action);
	assign x9         = {1'b0, it_q.x};
	assign ipg5       = (act == ACT_DRAW) ? it_q.y[7:3] : {2'b00, it_q.page};
	assign item_faddr = {ipg5[PAGE_W-1:0], it_q.x[COL_W-1:0]};
	assign item_word  = x9[BIT_W +: WRD_W];
	assign pix_mask   = 8'b1 << it_q.y[2:0];

	always_comb begin
		if (act == ACT_DRAW) begin
			new_byte = it_q.pixel_on ? (frd_q | pix_mask) : (frd_q & ~pix_mask);
		end else begin
			new_byte = it_q.byte_value;
		end
	end

	// Frame store port selection.
	assign fwe    = cmd.sweep_step || cmd.frm_wr;
	assign fwaddr = cmd.sweep_step ? sweep_q : item_faddr;
	assign fwdata = cmd.sweep_step ? 8'h00 : new_byte;
	assign fre    = cmd.frm_rd || cmd.hit_rd;
	assign fraddr = cmd.hit_rd ? {hit_page_q, hit_col_q} : item_faddr;

	always_ff @(posedge clk) begin
		if (fwe) fmem[fwaddr] <= fwdata;
		if (fre) frd_q <= fmem[fraddr];
	end

	// Dirty mark port selection: the sweep fills whole words, the others touch one bit.
	always_comb begin
		dwe    = cmd.sweep_step || cmd.frm_wr || cmd.hit_rd;
		dwaddr = sweep_q[DA_W-1:0];
		dwmask = '1;
		dwdata = {DIRTY_W{cmd.sweep_dirty}};
		if (cmd.frm_wr) begin
			dwaddr = {ipg5[PAGE_W-1:0], item_word};
			dwmask = DIRTY_W'(1) << it_q.x[BIT_W-1:0];
			dwdata = '1;
		end else if (cmd.hit_rd) begin
			dwaddr = {hit_page_q, hit_word_q};
			dwmask = DIRTY_W'(1) << hit_bit_q;
			dwdata = '0;
		end
	end

	always_ff @(posedge clk) begin
		for (int b = 0; b < DIRTY_W; b++) begin
			if (dwe && dwmask[b]) dmem[dwaddr][b] <= dwdata[b];
		end
		if (cmd.scan_rd) drd_q <= dmem[{sp_q, sw_q}];
	end

	// Scan word evaluation: lowest dirty column at or after the cursor.
	assign curcol9   = 9'(cur_col_q);
	assign col_base9 = 9'({sw_q, {BIT_W{1'b0}}});

	always_comb begin
		for (int b = 0; b < DIRTY_W; b++) begin
			vmask[b] = (col_base9 + 9'(b)) < 9'(COLUMNS);
			fmask[b] = !first_q || (BIT_W'(b) >= start_bit_q);
		end
	end

	assign masked = drd_q & vmask & fmask;

	always_comb begin
		hit_bit = '0;
		for (int b = DIRTY_W - 1; b >= 0; b--) begin
			if (masked[b]) hit_bit = BIT_W'(b);
		end
	end

	assign hit_col9 = col_base9 + 9'(hit_bit);
	assign col8     = 8'(hit_col_q);

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q      <= '0;
			cur_page_q   <= '0;
			cur_col_q    <= '0;
			page_valid_q <= 1'b0;
			sent_page_q  <= '0;
			sp_q         <= '0;
			sw_q         <= '0;
			scnt_q       <= '0;
			start_bit_q  <= '0;
			first_q      <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.sweep_step) sweep_q <= sweep_q + FA_W'(1);

			if (cmd.scan_start) begin
				sp_q        <= cur_page_q;
				sw_q        <= curcol9[BIT_W +: WRD_W];
				start_bit_q <= cur_col_q[BIT_W-1:0];
				first_q     <= 1'b1;
				scnt_q      <= '0;
			end else if (cmd.scan_next) begin
				first_q <= 1'b0;
				scnt_q  <= scnt_q + SCNT_W'(1);
				if (sw_q == WRD_W'(WPP - 1)) begin
					sw_q <= '0;
					sp_q <= (sp_q == PAGE_W'(PAGES - 1)) ? '0 : sp_q + PAGE_W'(1);
				end else begin
					sw_q <= sw_q + WRD_W'(1);
				end
			end

			if (cmd.hit_rd) begin
				if (hit_col_q == COL_W'(COLUMNS - 1)) begin
					cur_col_q  <= '0;
					cur_page_q <= (hit_page_q == PAGE_W'(PAGES - 1)) ? '0
					                                                 : hit_page_q + PAGE_W'(1);
				end else begin
					cur_col_q  <= hit_col_q + COL_W'(1);
					cur_page_q <= hit_page_q;
				end
			end else if (cmd.done_upd) begin
				cur_col_q    <= '0;
				cur_page_q   <= '0;
				page_valid_q <= 1'b0;
			end

			if (cmd.out_load && (cmd.out_sel == OUT_PAGE)) begin
				sent_page_q  <= hit_page_q;
				page_valid_q <= 1'b1;
			end

			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cmd.take_item) it_q <= item;

		if (cmd.scan_eval && stat.hit) begin
			hit_page_q <= sp_q;
			hit_word_q <= sw_q;
			hit_bit_q  <= hit_bit;
			hit_col_q  <= hit_col9[COL_W-1:0];
		end

		if (cmd.out_load) begin
			is_data_q <= 1'b0;
			last_q    <= 1'b0;
			done_q    <= 1'b0;
			case (cmd.out_sel)
				OUT_PAGE: out_byte_q <= PAGE_CMD + 8'(hit_page_q);
				OUT_HI:   out_byte_q <= COL_HI_CMD | ((col8 & HI_MASK) >> 4);
				OUT_LO:   out_byte_q <= col8 & LO_MASK;
				OUT_DATA: begin
					out_byte_q <= frd_q;
					is_data_q  <= 1'b1;
					last_q     <= 1'b1;
				end
				default: begin
					out_byte_q <= 8'h00;
					last_q     <= 1'b1;
					done_q     <= 1'b1;
				end
			endcase
		end
	end

	// Status to the controller.
	always_comb begin
		stat.act         = act;
		stat.in_range    = (x9 < 9'(COLUMNS)) && (ipg5 < 5'(PAGES));
		stat.differs     = (frd_q != it_q.byte_value);
		stat.hit         = |masked;
		stat.scan_end    = (scnt_q == SCNT_W'(SCAN_N - 1));
		stat.sweep_end   = &sweep_q;
		stat.page_needed = !page_valid_q || (sent_page_q != hit_page_q);
		stat.out_free    = !out_valid_q || out_ready;
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign is_data   = is_data_q;
	assign last      = last_q;
	assign done_res  = done_q;

`ifndef SYNTH
	a_load_into_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("output register loaded while an item still waits");

	a_done_item_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && done_q) |-> ((out_byte_q == 8'h00) && last_q && !is_data_q))
		else $error("done item carries a nonzero byte or wrong flags");

	a_data_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && is_data_q) |-> (last_q && !done_q))
		else $error("data item is not the last item of its step");

	a_one_dirty_writer: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sweep_step |-> !(cmd.frm_wr || cmd.hit_rd))
		else $error("sweep collides with another dirty mark write");
`endif

endmodule

FILE: hw/rtl/dirty_tracking_frame_refresh_core.sv
// Top level: page-organized frame store with dirty tracking and refresh command output.
// Draw point and write byte are decoded, read and modified before the next item is taken.
// An ignored item goes back to idle after decode. Clear sweeps the whole store, one entry a cycle.
// Refresh reads the dirty marks one word of 16 columns at a time; a hit reads its frame byte and
// sends 3 or 4 output items, and a pass with nothing dirty reads all 65 words.
// After reset a clearing pass zeroes store and marks before the first item is taken.
module dirty_tracking_frame_refresh_core import dtfr_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	dtfr_in_if.sink  req,
	dtfr_out_if.source rsp
);

	// The controller decides the sequence; the datapath holds all storage and the output
	// register, so a finished item can wait for the sink while the next item is taken.
	dtfr_cmd_t  cmd;
	dtfr_stat_t stat;
	item_t      item;
	logic       in_ready;

	// Pack the channel payload into one item word for the datapath.
	always_comb begin
		item.action     = req.action;
		item.x          = req.x;
		item.y          = req.y;
		item.pixel_on   = req.pixel_on;
		item.page       = req.page;
		item.byte_value = req.byte_value;
	end

	assign req.ready = in_ready;

	dtfr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Every result item leaves through the datapath's output register.
	dtfr_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.item      (item),
		.out_ready (rsp.ready),
		.out_valid (rsp.valid),
		.out_byte  (rsp.out_byte),
		.is_data   (rsp.is_data),
		.last      (rsp.last),
		.done_res  (rsp.done_res)
	);

endmodule

FILE: test/tb_dirty_tracking_frame_refresh_core.sv
// Testbench of the dirty tracking frame refresh core: directed and random items against a predictor.
module tb_dirty_tracking_frame_refresh_core;
	timeunit 1ns;
	timeprecision 1ps;

	import dtfr_pkg::*;

	localparam int CELLS = COLUMNS * PAGES;
	// Longest silent stretch of the core: a clear sweeps every entry once, plus some margin.
	localparam int TAIL_CYCLES = 1200;
	// Length of the long output hold-off that fills the core and stalls its input.
	localparam int HOLD_CYCLES = 400;

	// One byte item toward the display controller, as the core presents it.
	typedef struct packed {
		logic [7:0] out_byte;
		logic       is_data;
		logic       last_flag;
		logic       done_flag;
	} disp_word_t;

	logic clk;
	logic arst_n;

	dtfr_in_if  req_if ();
	dtfr_out_if rsp_if ();

	dirty_tracking_frame_refresh_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	// Shadow copy of the frame store, the per-byte dirty marks and the scan position.
	// The core groups its marks in words of DIRTY_W columns only to speed up the search, so
	// the shadow searches the byte marks directly.
	logic [7:0] shadow_frame [CELLS];
	bit         shadow_dirty [CELLS];
	int         scan_pos;
	bit         page_sent;
	int         sent_page;

	// Display bytes predicted but not yet seen, oldest first.
	disp_word_t pending_bytes [$];

	int mismatches     = 0;
	int items_taken    = 0;
	int live_items     = 0;
	int bytes_checked  = 0;
	int done_seen      = 0;
	int page_cmds_seen = 0;

	// Idling knobs, in percent, and the remaining cycles of a forced output hold-off.
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_left      = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Safety net: a correct run ends long before this.
	initial begin
		#3_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	function automatic void push_byte(logic [7:0] b, logic d, logic l, logic dn);
		disp_word_t w;
		w.out_byte  = b;
		w.is_data   = d;
		w.last_flag = l;
		w.done_flag = dn;
		pending_bytes.push_back(w);
	endfunction

	// A refresh step: find the next dirty byte from the scan position on, wrapping at the
	// end of the store, and predict the page, column and data bytes it sends.
	function automatic void predict_refresh();
		int hit_idx;
		int pg;
		logic [7:0] col_b;
		hit_idx = -1;
		for (int n = 0; n < CELLS; n++) begin
			int idx;
			idx = (scan_pos + n) % CELLS;
			if (shadow_dirty[idx]) begin
				hit_idx = idx;
				break;
			end
		end
		if (hit_idx < 0) begin
			// Nothing dirty: a single done item, and the next pass restarts from the top
			// with a fresh page command.
			push_byte(8'h00, 1'b0, 1'b1, 1'b1);
			scan_pos  = 0;
			page_sent = 1'b0;
			return;
		end
		pg    = hit_idx / COLUMNS;
		col_b = 8'(hit_idx % COLUMNS);
		if (!page_sent || sent_page != pg) begin
			push_byte(PAGE_CMD + 8'(pg), 1'b0, 1'b0, 1'b0);
			sent_page = pg;
			page_sent = 1'b1;
		end
		push_byte(COL_HI_CMD | ((col_b & HI_MASK) >> 4), 1'b0, 1'b0, 1'b0);
		push_byte(col_b & LO_MASK, 1'b0, 1'b0, 1'b0);
		push_byte(shadow_frame[hit_idx], 1'b1, 1'b1, 1'b0);
		shadow_dirty[hit_idx] = 1'b0;
		scan_pos = (hit_idx + 1) % CELLS;
	endfunction

	// Apply one accepted item to the shadow state. Returns 0 when the core ignores it.
	function automatic bit predict_item(item_t it);
		int pg;
		int fidx;
		logic [7:0] mask;
		case (action_t'(it.action))
			ACT_DRAW: begin
				pg = int'(it.y) >> 3;
				if (it.x >= COLUMNS || pg >= PAGES)
					return 1'b0;
				fidx = pg * COLUMNS + int'(it.x);
				mask = 8'd1 << it.y[2:0];
				if (it.pixel_on)
					shadow_frame[fidx] = shadow_frame[fidx] | mask;
				else
					shadow_frame[fidx] = shadow_frame[fidx] & ~mask;
				shadow_dirty[fidx] = 1'b1;
				return 1'b1;
			end
			ACT_WRITE: begin
				if (it.x >= COLUMNS || int'(it.page) >= PAGES)
					return 1'b0;
				fidx = int'(it.page) * COLUMNS + int'(it.x);
				// An unchanged byte needs no resend, so it raises no mark.
				if (shadow_frame[fidx] == it.byte_value)
					return 1'b0;
				shadow_frame[fidx] = it.byte_value;
				shadow_dirty[fidx] = 1'b1;
				return 1'b1;
			end
			ACT_CLEAR: begin
				// The scan position and the last sent page survive a clear.
				for (int i = 0; i < CELLS; i++) begin
					shadow_frame[i] = 8'h00;
					shadow_dirty[i] = 1'b1;
				end
				return 1'b1;
			end
			default: begin
				predict_refresh();
				return 1'b1;
			end
		endcase
	endfunction

	function automatic item_t make_item(action_t a, int x, int y, bit on, int pg,
			logic [7:0] v);
		item_t it;
		it.action     = a;
		it.x          = 8'(x);
		it.y          = 8'(y);
		it.pixel_on   = on;
		it.page       = 3'(pg);
		it.byte_value = v;
		return it;
	endfunction

	// An item of the given action with every field random.
	function automatic item_t any_item(action_t a);
		return make_item(a, $urandom_range(255), $urandom_range(255),
			1'($urandom_range(1)), $urandom_range(7), 8'($urandom_range(255)));
	endfunction

	// Offer one item, with random idle cycles ahead of it, and hold it until the core
	// takes it. Valid stays high on return so that back-to-back items need no gap.
	task automatic send_item(item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid      <= 1'b1;
		req_if.action     <= it.action;
		req_if.x          <= it.x;
		req_if.y          <= it.y;
		req_if.pixel_on   <= it.pixel_on;
		req_if.page       <= it.page;
		req_if.byte_value <= it.byte_value;
		do @(posedge clk); while (req_if.ready !== 1'b1);
		items_taken++;
		if (predict_item(it))
			live_items++;
	endtask

	// Stop offering and wait until every predicted byte has come out.
	task automatic wait_drained();
		req_if.valid <= 1'b0;
		do @(posedge clk); while (pending_bytes.size() != 0);
	endtask

	function automatic void report_mismatch(string what, disp_word_t want, disp_word_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("[%0t] %s: expected %h/%b/%b/%b, got %h/%b/%b/%b",
				$realtime, what, want.out_byte, want.is_data, want.last_flag,
				want.done_flag, got.out_byte, got.is_data, got.last_flag,
				got.done_flag);
	endfunction

	// Output side: check each accepted byte item against the oldest prediction, then pick
	// the ready level for the next cycle. A forced hold-off overrides the random stalls.
	initial begin
		disp_word_t got;
		disp_word_t want;
		rsp_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
				got.out_byte  = rsp_if.out_byte;
				got.is_data   = rsp_if.is_data;
				got.last_flag = rsp_if.last;
				got.done_flag = rsp_if.done_res;
				bytes_checked++;
				if (pending_bytes.size() == 0) begin
					report_mismatch("unexpected byte", '0, got);
				end else begin
					want = pending_bytes.pop_front();
					if (got.out_byte !== want.out_byte || got.is_data !== want.is_data ||
							got.last_flag !== want.last_flag ||
							got.done_flag !== want.done_flag)
						report_mismatch("byte mismatch", want, got);
					if (want.done_flag)
						done_seen++;
					else if (!want.is_data && (want.out_byte & HI_MASK) == PAGE_CMD)
						page_cmds_seen++;
				end
			end
			if (hold_left > 0) begin
				rsp_if.ready <= 1'b0;
				hold_left--;
			end else begin
				rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Corner items: an empty store, two opposite corners of the address space, out-of-range
	// points and bytes, a rewrite of an unchanged byte, both pixel levels, two hits on one
	// page, a repeated done, and a scan that wraps back to a byte just behind the cursor.
	task automatic test_directed();
		item_t seq [$];
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		seq.push_back(any_item(ACT_REFRESH));
		seq.push_back(make_item(ACT_DRAW, 0, 0, 1'b1, 5, 8'h33));
		seq.push_back(make_item(ACT_DRAW, 127, 63, 1'b1, 0, 8'h00));
		seq.push_back(make_item(ACT_DRAW, 128, 5, 1'b1, 2, 8'h11));
		seq.push_back(make_item(ACT_DRAW, 5, 64, 1'b1, 7, 8'hff));
		seq.push_back(make_item(ACT_DRAW, 255, 255, 1'b1, 7, 8'hff));
		seq.push_back(make_item(ACT_DRAW, 0, 0, 1'b0, 0, 8'h00));
		seq.push_back(make_item(ACT_DRAW, 0, 7, 1'b1, 3, 8'h80));
		seq.push_back(make_item(ACT_WRITE, 127, 0, 1'b0, 7, 8'h80));
		seq.push_back(make_item(ACT_WRITE, 200, 0, 1'b1, 3, 8'hff));
		seq.push_back(make_item(ACT_WRITE, 16, 200, 1'b1, 0, 8'hff));
		seq.push_back(make_item(ACT_WRITE, 127, 255, 1'b0, 7, 8'hff));
		seq.push_back(make_item(ACT_WRITE, 64, 17, 1'b1, 3, 8'h5a));
		repeat (5) seq.push_back(any_item(ACT_REFRESH));
		seq.push_back(any_item(ACT_REFRESH));
		seq.push_back(make_item(ACT_DRAW, 3, 8, 1'b1, 6, 8'h00));
		seq.push_back(any_item(ACT_REFRESH));
		seq.push_back(make_item(ACT_WRITE, 3, 9, 1'b0, 1, 8'h00));
		seq.push_back(any_item(ACT_REFRESH));
		seq.push_back(any_item(ACT_REFRESH));
		foreach (seq[i])
			send_item(seq[i]);
		wait_drained();
	endtask

	// Random bursts of edits clustered on one page, each followed by enough refresh steps
	// to drain it at times, with some fully random noise items mixed in.
	task automatic test_random_phase(int send_pct, int recv_pct, int quota);
		int goal;
		int base_pg;
		int edits;
		item_t it;
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
		goal = live_items + quota;
		while (live_items < goal) begin
			if ($urandom_range(99) < 12) begin
				case ($urandom_range(2))
					0: it = any_item(ACT_DRAW);
					1: it = any_item(ACT_WRITE);
					default: it = any_item(ACT_REFRESH);
				endcase
				send_item(it);
			end else begin
				base_pg = $urandom_range(PAGES - 1);
				edits   = $urandom_range(1, 5);
				repeat (edits) begin
					if ($urandom_range(99) < 60) begin
						it = any_item(ACT_DRAW);
						if ($urandom_range(9) != 0)
							it.y = 8'(base_pg * 8 + $urandom_range(7));
						if ($urandom_range(9) != 0)
							it.x[7] = 1'b0;
					end else begin
						it = any_item(ACT_WRITE);
						if ($urandom_range(3) != 0)
							it.page = 3'(base_pg);
						if ($urandom_range(9) != 0)
							it.x[7] = 1'b0;
						// Sometimes rewrite the byte already stored, which must stay clean.
						if (it.x < COLUMNS && $urandom_range(3) == 0)
							it.byte_value = shadow_frame[int'(it.page) * COLUMNS + int'(it.x)];
					end
					send_item(it);
				end
				repeat ($urandom_range(1, edits + 2))
					send_item(any_item(ACT_REFRESH));
			end
		end
		wait_drained();
	endtask

	// The output is held off for a long stretch while the sender keeps offering edits and
	// refresh steps, so the core fills up and has to stall its input.
	task automatic test_backpressure();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_left      = HOLD_CYCLES;
		for (int i = 0; i < 10; i++)
			send_item(make_item(ACT_DRAW, i * 8, (i % 8) * 8 + i % 8, 1'b1, 0, 8'h00));
		repeat (10)
			send_item(any_item(ACT_REFRESH));
		wait_drained();
	endtask

	// Clear marks every byte dirty, so it comes last: from then on no pass can finish.
	task automatic test_clear();
		send_idle_pct  = 14;
		recv_stall_pct = 14;
		send_item(any_item(ACT_CLEAR));
		send_item(make_item(ACT_WRITE, 9, 0, 1'b0, 0, 8'h00));
		send_item(make_item(ACT_DRAW, 9, 2, 1'b1, 0, 8'h00));
		repeat (20)
			send_item(any_item(ACT_REFRESH));
		send_item(make_item(ACT_WRITE, 127, 0, 1'b1, 7, 8'ha5));
		repeat (6)
			send_item(any_item(ACT_REFRESH));
		wait_drained();
	endtask

	initial begin
		arst_n            <= 1'b0;
		req_if.valid      <= 1'b0;
		req_if.action     <= ACT_DRAW;
		req_if.x          <= 8'h00;
		req_if.y          <= 8'h00;
		req_if.pixel_on   <= 1'b0;
		req_if.page       <= 3'd0;
		req_if.byte_value <= 8'h00;
		for (int i = 0; i < CELLS; i++) begin
			shadow_frame[i] = 8'h00;
			shadow_dirty[i] = 1'b0;
		end
		scan_pos  = 0;
		page_sent = 1'b0;
		sent_page = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_random_phase(0, 0, 5);
		test_random_phase(58, 0, 5);
		test_random_phase(0, 58, 5);
		test_random_phase(14, 14, 5);
		test_backpressure();
		test_clear();

		// A trailing clear or edit makes no output, so give the core time to show any
		// stray byte item before judging.
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Run covered %0d action items (%0d with effect) and %0d display bytes,",
			items_taken, live_items, bytes_checked);
		$display("with %0d done reports and %0d page commands, four idling mixes, %s",
			done_seen, page_cmds_seen, "a long output hold-off and a clear.");
		if (mismatches == 0 && pending_bytes.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
